// ===== rtl/rli2d_pkg.sv =====
// Shared types and constants for the 2D ray and line intersection pipeline.
package rli2d_pkg;

   localparam int unsigned CoordWidth  = 32;
   localparam int unsigned DistWidth   = 31;
   localparam int unsigned NormWidth   = 18;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned ReqDataWidth = 128;
   localparam int unsigned RspDataWidth = 136;

   // Register indexes of the configuration channel.
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_LINE_START_X  = 3'd0,
      CSR_LINE_START_Y  = 3'd1,
      CSR_LINE_END_X    = 3'd2,
      CSR_LINE_END_Y    = 3'd3,
      CSR_PARALLEL_EPS  = 3'd4
   } csr_index_type;

   localparam logic [31:0] EpsilonReset = 32'd4295;
   localparam logic signed [31:0] SatMax = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SatMin = 32'sh8000_0000;

endpackage

// ===== rtl/rli2d_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module rli2d_divider
   import rli2d_pkg::*;
#(
   parameter int unsigned NumWidth = 96,
   parameter int unsigned DenWidth = 66,
   parameter int unsigned QuoWidth = 34,
   parameter int unsigned TagWidth = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic [NumWidth-1:0] in_num,
   input  logic [DenWidth-1:0] in_den,
   input  logic [TagWidth-1:0] in_tag,
   output logic                out_valid,
   output logic [QuoWidth-1:0] out_quo,
   output logic                out_ovf,
   output logic [TagWidth-1:0] out_tag
);
   // The quotient is formed only over its low QuoWidth bits; out_ovf flags a
   // quotient at or above 2^QuoWidth, decided by the top compare.
   localparam int unsigned RemWidth = DenWidth + 1;

   logic [RemWidth-1:0] rem_ff   [QuoWidth+1];
   logic [NumWidth-1:0] num_ff   [QuoWidth+1];
   logic [DenWidth-1:0] den_ff   [QuoWidth+1];
   logic [QuoWidth-1:0] quo_ff   [QuoWidth+1];
   logic [TagWidth-1:0] tag_ff   [QuoWidth+1];
   logic                ovf_ff   [QuoWidth+1];
   logic                vld_ff   [QuoWidth+1];

   // Stage 0: overflow test: num >= den * 2^QuoWidth.
   logic [NumWidth-1:0] hi_part;
   assign hi_part = in_num >> QuoWidth;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_valid;
      end
      if (enable) begin
         num_ff[0] <= in_num;
         den_ff[0] <= in_den;
         tag_ff[0] <= in_tag;
         quo_ff[0] <= '0;
         ovf_ff[0] <= (hi_part >= NumWidth'(in_den));
         rem_ff[0] <= RemWidth'(hi_part);
      end
   end

   for (genvar k = 0; k < QuoWidth; k++) begin : g_stage
      localparam int unsigned Bit = QuoWidth - 1 - k;
      logic [RemWidth-1:0] trial;
      logic [RemWidth:0]   diff;
      assign trial = {rem_ff[k][RemWidth-2:0], num_ff[k][Bit]};
      assign diff  = {1'b0, trial} - {2'b00, den_ff[k]};
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (enable) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (enable) begin
            num_ff[k+1] <= num_ff[k];
            den_ff[k+1] <= den_ff[k];
            tag_ff[k+1] <= tag_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            if (!diff[RemWidth] && !ovf_ff[k]) begin
               rem_ff[k+1] <= diff[RemWidth-1:0];
               quo_ff[k+1] <= quo_ff[k] | (QuoWidth'(1) << Bit);
            end else begin
               rem_ff[k+1] <= ovf_ff[k] ? rem_ff[k] : trial;
               quo_ff[k+1] <= quo_ff[k];
            end
         end
      end
   end

   assign out_valid = vld_ff[QuoWidth];
   assign out_quo   = quo_ff[QuoWidth];
   assign out_ovf   = ovf_ff[QuoWidth];
   assign out_tag   = tag_ff[QuoWidth];
endmodule

// ===== rtl/ray_line_intersect_2d.sv =====
// Top level of the 2D ray against fixed line intersection pipeline.
// Pipeline from an accepted req word to its rsp word: five front stages,
//   three divider pipelines of 35 stages each in parallel, one output register.
// Throughput: one ray per cycle; the whole pipeline stalls on rsp back-pressure.
// Reset: synchronous active-high; clears valid bits and the line, epsilon goes to 4295.
//   The line normal is searched again after each configuration write.
module ray_line_intersect_2d
   import rli2d_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [31:0]             csr_data,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y
   input  logic [ReqDataWidth-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // point_x, point_y, distance, normal_x, normal_y, 5 zero bits
   output logic [RspDataWidth-1:0] rsp_tdata,
   // hit
   output logic                    rsp_tuser
);

   localparam int unsigned PreStages = 5;
   localparam int unsigned DivQuo    = 34;
   localparam int unsigned TotalLat  = PreStages + DivQuo + 1 + 1;
   localparam int unsigned ShWidth   = 33;

   // ------------------------------------------------------------------ CSRs
   logic signed [31:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic [31:0]        eps_ff;
   logic signed [32:0] ldx_ff, ldy_ff;
   logic [16:0]        nx_ff, ny_ff;
   logic [6:0]         ncnt_ff;
   logic               dirty_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff    <= '0;
         sy_ff    <= '0;
         ex_ff    <= '0;
         ey_ff    <= '0;
         eps_ff   <= EpsilonReset;
         dirty_ff <= 1'b1;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_LINE_START_X: sx_ff  <= csr_data;
               CSR_LINE_START_Y: sy_ff  <= csr_data;
               CSR_LINE_END_X:   ex_ff  <= csr_data;
               CSR_LINE_END_Y:   ey_ff  <= csr_data;
               CSR_PARALLEL_EPS: eps_ff <= csr_data;
               default: ;
            endcase
         end
         dirty_ff <= csr_valid;
      end
   end

   always_ff @(posedge clock) begin
      ldx_ff <= 33'(ex_ff) - 33'(sx_ff);
      ldy_ff <= 33'(ey_ff) - 33'(sy_ff);
   end

   // Normal magnitude: bit-serial search, one bit of m per step, MSB first.
   // Test m^2*|L|^2 <= 2^32*c^2 for both components at once. After |L|^2
   // has settled, each step squares the trial value, multiplies it by the low
   // and then the high half of |L|^2, and compares.
   localparam int unsigned NormWarm = 3;
   localparam int unsigned NormDone = NormWarm + 4 * 17;

   logic [32:0] ap, aq;
   assign ap = ldx_ff[32] ? 33'(-ldx_ff) : 33'(ldx_ff);
   assign aq = ldy_ff[32] ? 33'(-ldy_ff) : 33'(ldy_ff);

   logic [6:0]  nrel;
   logic [1:0]  nphase;
   logic [16:0] cx, cy;
   logic [4:0]  bitpos;
   assign nrel   = ncnt_ff - 7'(NormWarm);
   assign nphase = nrel[1:0];
   assign bitpos = 5'd16 - nrel[6:2];
   assign cx = nx_ff | (17'd1 << bitpos[4:0]);
   assign cy = ny_ff | (17'd1 << bitpos[4:0]);

   // |L|^2 computed continuously from the line deltas, then compare m^2*|L|^2 <= 2^32*c^2.
   logic [66:0]  len2_ff;
   logic [65:0]  px2_ff, py2_ff;
   logic [33:0]  sqx_ff, sqy_ff;
   logic [100:0] accx_ff, accy_ff;
   always_ff @(posedge clock) begin
      px2_ff  <= 66'(ap) * 66'(ap);
      py2_ff  <= 66'(aq) * 66'(aq);
      len2_ff <= 67'(px2_ff) + 67'(py2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || dirty_ff) begin
         ncnt_ff <= '0;
         nx_ff   <= '0;
         ny_ff   <= '0;
      end else if (ncnt_ff < 7'(NormDone)) begin
         ncnt_ff <= ncnt_ff + 7'd1;
         if (ncnt_ff >= 7'(NormWarm)) begin
            case (nphase)
               2'd0: begin
                  sqx_ff <= 34'(cx) * 34'(cx);
                  sqy_ff <= 34'(cy) * 34'(cy);
               end
               2'd1: begin
                  accx_ff <= 101'(68'(sqx_ff) * 68'(len2_ff[33:0]));
                  accy_ff <= 101'(68'(sqy_ff) * 68'(len2_ff[33:0]));
               end
               2'd2: begin
                  accx_ff <= accx_ff + {67'(sqx_ff) * 67'(len2_ff[66:34]), 34'b0};
                  accy_ff <= accy_ff + {67'(sqy_ff) * 67'(len2_ff[66:34]), 34'b0};
               end
               default: begin
                  if (accx_ff <= {3'b0, py2_ff, 32'b0}) nx_ff <= cx;
                  if (accy_ff <= {3'b0, px2_ff, 32'b0}) ny_ff <= cy;
               end
            endcase
         end
      end
   end

   // ------------------------------------------------------------- pipeline
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Stage 1: operands.
   logic               v1_ff;
   logic signed [32:0] ox1_ff, oy1_ff;
   logic signed [31:0] dx1_ff, dy1_ff, orx1_ff, ory1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_tvalid;
      if (adv) begin
         orx1_ff <= req_tdata[31:0];
         ory1_ff <= req_tdata[63:32];
         dx1_ff  <= req_tdata[95:64];
         dy1_ff  <= req_tdata[127:96];
         ox1_ff  <= 33'(signed'(req_tdata[31:0])) - 33'(sx_ff);
         oy1_ff  <= 33'(signed'(req_tdata[63:32])) - 33'(sy_ff);
      end
   end

   // Stage 2: four products.
   logic               v2_ff;
   logic signed [65:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [31:0] dx2_ff, dy2_ff, orx2_ff, ory2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         p1_ff   <= 66'(ldx_ff) * 66'(dy1_ff);
         p2_ff   <= 66'(ldy_ff) * 66'(dx1_ff);
         p3_ff   <= 66'(ox1_ff) * 66'(ldy_ff);
         p4_ff   <= 66'(oy1_ff) * 66'(ldx_ff);
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         orx2_ff <= orx1_ff;
         ory2_ff <= ory1_ff;
      end
   end

   // Stage 3: cross products, magnitudes and decisions.
   logic               v3_ff, hit3_ff;
   logic [66:0]        detm3_ff, numm3_ff;
   logic               detneg3_ff;
   logic signed [31:0] dx3_ff, dy3_ff, orx3_ff, ory3_ff;
   logic signed [66:0] det_w, num_w;
   logic [66:0]        detm_w, numm_w;
   logic               hit_w;
   assign det_w  = 67'(p1_ff) - 67'(p2_ff);
   assign num_w  = 67'(p3_ff) - 67'(p4_ff);
   assign detm_w = det_w[66] ? 67'(-det_w) : 67'(det_w);
   assign numm_w = num_w[66] ? 67'(-num_w) : 67'(num_w);
   assign hit_w  = (detm_w != '0) && (detm_w >= 67'(eps_ff))
                   && ((numm_w == '0) || (num_w[66] == det_w[66]));
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
      if (adv) begin
         hit3_ff    <= hit_w;
         detm3_ff   <= detm_w;
         numm3_ff   <= numm_w;
         detneg3_ff <= det_w[66];
         dx3_ff     <= dx2_ff;
         dy3_ff     <= dy2_ff;
         orx3_ff    <= orx2_ff;
         ory3_ff    <= ory2_ff;
      end
   end

   // Stages 4-5: num*|dx|, num*|dy| as two half products, then summed.
   logic [31:0]  adx, ady;
   assign adx = dx3_ff[31] ? 32'(-33'(dx3_ff)) : 32'(dx3_ff);
   assign ady = dy3_ff[31] ? 32'(-33'(dy3_ff)) : 32'(dy3_ff);
   logic         v4_ff, v5_ff;
   logic [63:0]  xl4_ff, yl4_ff;
   logic [66:0]  xh4_ff, yh4_ff;
   logic [66:0]  numm4_ff, detm4_ff, numm5_ff, detm5_ff;
   logic [98:0]  offx5_ff, offy5_ff;
   typedef struct packed {
      logic               hit;
      logic               detneg;
      logic               nx_neg;
      logic               ny_neg;
      logic signed [31:0] orx;
      logic signed [31:0] ory;
   } side_type;
   side_type sd4_ff, sd5_ff;
   logic nxs_w, nys_w;
   assign nxs_w = (ldy_ff > 0) ^ !detneg3_ff;
   assign nys_w = (ldx_ff < 0) ^ !detneg3_ff;
   logic xneg4_ff, yneg4_ff, xneg5_ff, yneg5_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      if (adv) begin
         xl4_ff   <= 64'(numm3_ff[31:0]) * 64'(adx);
         yl4_ff   <= 64'(numm3_ff[31:0]) * 64'(ady);
         xh4_ff   <= 67'(numm3_ff[66:32]) * 67'(adx);
         yh4_ff   <= 67'(numm3_ff[66:32]) * 67'(ady);
         numm4_ff <= numm3_ff;
         detm4_ff <= detm3_ff;
         xneg4_ff <= dx3_ff[31];
         yneg4_ff <= dy3_ff[31];
         sd4_ff   <= '{hit: hit3_ff, detneg: detneg3_ff, nx_neg: nxs_w,
                       ny_neg: nys_w, orx: orx3_ff, ory: ory3_ff};
         offx5_ff <= 99'(xl4_ff) + {xh4_ff[66:0], 32'b0};
         offy5_ff <= 99'(yl4_ff) + {yh4_ff[66:0], 32'b0};
         numm5_ff <= numm4_ff;
         detm5_ff <= detm4_ff;
         xneg5_ff <= xneg4_ff;
         yneg5_ff <= yneg4_ff;
         sd5_ff   <= sd4_ff;
      end
   end

   // Dividers: point offsets (quotient range checked at 2^34) and distance.
   typedef struct packed {
      side_type s;
      logic     xneg;
      logic     yneg;
   } tag_type;
   localparam int unsigned TagW = $bits(tag_type);
   tag_type tin, tout, tdum1, tdum2;
   assign tin = '{s: sd5_ff, xneg: xneg5_ff, yneg: yneg5_ff};

   logic dvx, dvy, dvd, ovx, ovy, ovd;
   logic [DivQuo-1:0] qx, qy, qd;
   logic [66:0] den_w;
   assign den_w = (detm5_ff == '0) ? 67'd1 : detm5_ff;

   rli2d_divider #(.NumWidth(99), .DenWidth(67), .QuoWidth(DivQuo), .TagWidth(TagW))
   u_div_x (.clock, .reset, .enable(adv), .in_valid(v5_ff), .in_num(offx5_ff),
            .in_den(den_w), .in_tag(tin), .out_valid(dvx), .out_quo(qx),
            .out_ovf(ovx), .out_tag(tout));
   rli2d_divider #(.NumWidth(99), .DenWidth(67), .QuoWidth(DivQuo), .TagWidth(TagW))
   u_div_y (.clock, .reset, .enable(adv), .in_valid(v5_ff), .in_num(offy5_ff),
            .in_den(den_w), .in_tag(tin), .out_valid(dvy), .out_quo(qy),
            .out_ovf(ovy), .out_tag(tdum1));
   rli2d_divider #(.NumWidth(83), .DenWidth(67), .QuoWidth(DivQuo), .TagWidth(TagW))
   u_div_d (.clock, .reset, .enable(adv), .in_valid(v5_ff),
            .in_num({numm5_ff, 16'b0}), .in_den(den_w), .in_tag(tin),
            .out_valid(dvd), .out_quo(qd), .out_ovf(ovd), .out_tag(tdum2));

   // Final stage: saturation, normal sign, zeroing on a miss.
   function automatic logic [31:0] sat_pt(logic signed [31:0] o, logic neg,
                                         logic ovf, logic [DivQuo-1:0] q);
      logic signed [35:0] v;
      begin
         v = neg ? (36'(o) - 36'(q)) : (36'(o) + 36'(q));
         if (ovf || q > 34'h2_0000_0000) sat_pt = neg ? SatMin : SatMax;
         else if (v > 36'(SatMax)) sat_pt = SatMax;
         else if (v < 36'(SatMin)) sat_pt = SatMin;
         else sat_pt = v[31:0];
      end
   endfunction

   logic [31:0] px_w, py_w;
   logic [30:0] dist_w;
   logic [17:0] nxo_w, nyo_w;
   assign px_w   = sat_pt(tout.s.orx, tout.xneg, ovx, qx);
   assign py_w   = sat_pt(tout.s.ory, tout.yneg, ovy, qy);
   assign dist_w = (ovd || qd > 34'h7FFF_FFFF) ? 31'h7FFF_FFFF : qd[30:0];
   assign nxo_w  = tout.s.nx_neg ? 18'(-18'(nx_ff)) : 18'(nx_ff);
   assign nyo_w  = tout.s.ny_neg ? 18'(-18'(ny_ff)) : 18'(ny_ff);

   logic                    ov_ff;
   logic [RspDataWidth-1:0] od_ff;
   logic                    oh_ff;
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (adv) ov_ff <= dvx;
      if (adv) begin
         oh_ff <= tout.s.hit;
         od_ff <= tout.s.hit ? {5'b0, nyo_w, nxo_w, dist_w, py_w, px_w} : '0;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = oh_ff;

`ifndef SYNTHESIS
   // The three dividers run in lockstep, so their valid outputs agree.
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      (dvx == dvy) && (dvx == dvd))
      else $error("divider valid bits diverged");
   // A stalled response word holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed under stall");
   // A miss carries an all-zero payload.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss with nonzero payload");
`endif

   logic unused_ok;
   assign unused_ok = ^{tdum1, tdum2, TotalLat[0], ShWidth[0], tout.s.detneg, eps_ff[0]};
endmodule
